// ===== rtl/core/pin_time_schedule_switch_macros.svh =====
// Assertion helpers used by the schedule switch to check its own logic.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef PIN_TIME_SCHEDULE_SWITCH_MACROS_SVH
`define PIN_TIME_SCHEDULE_SWITCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTSS_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pin schedule switch: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTSS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pin schedule switch: next-cycle check failed");

`endif

// ===== rtl/core/ptss_pkg.sv =====
package ptss_pkg;

    // Sizes of the item fields.
    localparam int NUM_PINS_DEFAULT = 40;
    localparam int PIN_W            = 6;
    localparam int TIME_W           = 33;
    localparam int MIN_W            = 11;
    localparam int DAYS_IN_W        = 8;
    localparam int DAYS_W           = 7;
    localparam int WDAY_W           = 3;
    localparam int ID_W             = 32;
    localparam int STATUS_W         = 3;
    localparam int MODE_W           = 2;
    localparam int MASK_W           = 40;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 64;

    // Limits checked by the add command.
    localparam logic [PIN_W-1:0]     PIN_MAX    = 6'd39;
    localparam logic [TIME_W-1:0]    TIME_MAX   = 33'd4102444800;
    localparam logic [MIN_W-1:0]     MINUTE_MAX = 11'd1440;
    localparam logic [DAYS_IN_W-1:0] DAYS_MAX   = 8'd127;

    // Command codes.
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PIN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TIME    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_CLEARED = 3'd5;

    // One stored schedule.
    typedef struct packed {
        logic              weekly;
        logic [TIME_W-1:0] start_s;
        logic [TIME_W-1:0] end_s;
        logic [DAYS_W-1:0] days;
        logic [MIN_W-1:0]  on_m;
        logic [MIN_W-1:0]  off_m;
    } slot_t;

    // Time carried by a tick.
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [WDAY_W-1:0] weekday;
        logic [MIN_W-1:0]  minute;
    } tick_t;

    // Verdict of the evaluation unit for one slot.
    typedef struct packed {
        logic want;
        logic level;
        logic expire;
    } eval_t;

endpackage

// ===== rtl/core/pin_time_schedule_switch.sv =====
// Add, clear and unused commands: the item is latched when accepted and its result is registered
// once the output register is free. Tick: one pin per cycle, unless a result waits on a stalled
// output, through the single read port of the schedule memory and the shared evaluation unit.
// A new item is taken only once the previous one has placed its last result.
// Reset (rst_n, asynchronous, active low) clears the valid, remembered and driven
// bits, the present mask and the sequencer, and sets the next id to one.
module pin_time_schedule_switch #(
    parameter int NUM_PINS = ptss_pkg::NUM_PINS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ptss_pkg::MODE_W-1:0]     mode,
    input  logic [ptss_pkg::PIN_W-1:0]      pin,
    input  logic                            schedule_kind,
    input  logic [ptss_pkg::TIME_W-1:0]     start_time,
    input  logic [ptss_pkg::TIME_W-1:0]     end_time,
    input  logic [ptss_pkg::DAYS_IN_W-1:0]  days_mask,
    input  logic [ptss_pkg::MIN_W-1:0]      on_minute,
    input  logic [ptss_pkg::MIN_W-1:0]      off_minute,
    input  logic [ptss_pkg::TIME_W-1:0]     now_seconds,
    input  logic [ptss_pkg::WDAY_W-1:0]     weekday,
    input  logic [ptss_pkg::MIN_W-1:0]      minute_of_day,
    // Output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ptss_pkg::PIN_W-1:0]      out_pin,
    output logic                            out_level,
    output logic                            pin_written,
    output logic [ptss_pkg::STATUS_W-1:0]   status,
    output logic [ptss_pkg::ID_W-1:0]       schedule_id,
    output logic                            last,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptss_pkg::ADDR_W-1:0]     paddr,
    input  logic [ptss_pkg::DATA_W-1:0]     pwdata,
    output logic [ptss_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import ptss_pkg::*;

    `include "pin_time_schedule_switch_macros.svh"

    localparam int CNT_W = $clog2(NUM_PINS + 1);
    localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    // Register index, taken from the 8-byte slot of the address.
    localparam logic REG_PIN_PRESENT = 1'b0;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMD   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_CLOSE = 2'd3;

    function automatic logic is_present(input logic [MASK_W-1:0] mask,
                                        input logic [PIN_W-1:0] p);
        is_present = (p <= PIN_MAX) && mask[p];
    endfunction

    logic [1:0]           state_reg, state_next;
    logic [MASK_W-1:0]    present_reg;
    logic [NUM_PINS-1:0]  slot_valid_reg, slot_valid_next;
    logic [NUM_PINS-1:0]  remembered_reg, remembered_next;
    logic [NUM_PINS-1:0]  driven_reg, driven_next;
    logic [ID_W-1:0]      next_id_reg, next_id_next;

    // Latched command fields.
    logic [MODE_W-1:0]    cmd_mode_reg;
    logic [PIN_W-1:0]     cmd_pin_reg;
    logic                 cmd_kind_reg;
    logic [TIME_W-1:0]    cmd_start_reg;
    logic [TIME_W-1:0]    cmd_end_reg;
    logic [DAYS_IN_W-1:0] cmd_days_reg;
    logic [MIN_W-1:0]     cmd_on_reg;
    logic [MIN_W-1:0]     cmd_off_reg;
    tick_t                tick_reg;

    // Scan pipeline.
    logic [CNT_W-1:0]     rd_addr_reg, rd_addr_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]     ev_pin_reg, ev_pin_next;
    logic                 rd_en;
    slot_t                rd_data_reg;
    eval_t                verdict;

    // Schedule memory.
    slot_t                slot_mem [NUM_PINS];
    logic                 mem_we;
    slot_t                mem_wdata;

    // Output register.
    logic                 out_valid_reg;
    logic [PIN_W-1:0]     out_pin_reg, out_pin_next;
    logic                 out_level_reg, out_level_next;
    logic                 out_written_reg, out_written_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_load;
    logic                 out_free;

    // Command decode.
    logic                 in_accept;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cmd_idx;
    logic                 cmd_pin_bad;
    logic [STATUS_W-1:0]  add_check;
    logic                 cmd_present;
    logic                 add_commit;

    // Scan decode.
    logic                 ev_slot_ok;
    logic                 ev_emit;
    logic                 ev_write;
    logic                 advance;
    logic                 scan_done;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[3] == REG_PIN_PRESENT);
    assign prdata = (paddr[3] == REG_PIN_PRESENT)
                    ? {{(DATA_W-MASK_W){1'b0}}, present_reg} : '0;

    // Field checks of the add command.
    assign cmd_idx     = cmd_pin_reg[IDX_W-1:0];
    assign cmd_pin_bad = (cmd_pin_reg > PIN_MAX) || (32'(cmd_pin_reg) >= NUM_PINS);
    assign cmd_present = is_present(present_reg, cmd_pin_reg);

    always_comb
    begin
        add_check = ST_OK;
        if (!cmd_kind_reg)
        begin
            if ((cmd_start_reg > TIME_MAX) || (cmd_end_reg > TIME_MAX))
            begin
                add_check = ST_BAD_TIME;
            end
            else if (cmd_end_reg <= cmd_start_reg)
            begin
                add_check = ST_BAD_RANGE;
            end
        end
        else
        begin
            if ((cmd_days_reg > DAYS_MAX) || (cmd_on_reg > MINUTE_MAX)
                || (cmd_off_reg > MINUTE_MAX))
            begin
                add_check = ST_BAD_TIME;
            end
            else if (cmd_on_reg == cmd_off_reg)
            begin
                add_check = ST_BAD_RANGE;
            end
        end
    end

    assign add_commit = (state_reg == S_CMD) && out_free && (cmd_mode_reg == MODE_ADD)
                        && !cmd_pin_bad && (add_check == ST_OK) && cmd_present;

    // Stored form of a new schedule; fields unused by its kind are zero.
    always_comb
    begin
        mem_wdata = '0;
        mem_wdata.weekly = cmd_kind_reg;
        if (cmd_kind_reg)
        begin
            mem_wdata.days  = cmd_days_reg[DAYS_W-1:0];
            mem_wdata.on_m  = cmd_on_reg;
            mem_wdata.off_m = cmd_off_reg;
        end
        else
        begin
            mem_wdata.start_s = cmd_start_reg;
            mem_wdata.end_s   = cmd_end_reg;
        end
    end

    // Shared evaluation unit, fed one slot per cycle while the scan is not held by a stalled output.
    ptss_eval u_eval (
        .slot    (rd_data_reg),
        .tick    (tick_reg),
        .verdict (verdict)
    );

    assign ev_slot_ok = slot_valid_reg[ev_pin_reg];
    assign ev_emit    = ev_valid_reg && ev_slot_ok && verdict.want
                        && (remembered_reg[ev_pin_reg] != verdict.level);
    assign ev_write   = is_present(present_reg, PIN_W'(ev_pin_reg))
                        && (driven_reg[ev_pin_reg] != verdict.level);
    assign advance    = !ev_emit || out_free;
    assign scan_done  = (rd_addr_reg == CNT_W'(NUM_PINS));

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        slot_valid_next  = slot_valid_reg;
        remembered_next  = remembered_reg;
        driven_next      = driven_reg;
        next_id_next     = next_id_reg;
        rd_addr_next     = rd_addr_reg;
        ev_valid_next    = ev_valid_reg;
        ev_pin_next      = ev_pin_reg;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        out_load         = 1'b0;
        out_pin_next     = '0;
        out_level_next   = 1'b0;
        out_written_next = 1'b0;
        out_status_next  = ST_OK;
        out_id_next      = '0;
        out_last_next    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == MODE_TICK)
                    begin
                        if (now_seconds != '0)
                        begin
                            state_next    = S_SCAN;
                            rd_addr_next  = '0;
                            ev_valid_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_CLOSE;
                        end
                    end
                    else
                    begin
                        state_next = S_CMD;
                    end
                end
            end

            S_CMD:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                    if ((cmd_mode_reg == MODE_ADD) || (cmd_mode_reg == MODE_CLEAR))
                    begin
                        if (cmd_pin_bad)
                        begin
                            out_status_next = ST_BAD_PIN;
                        end
                        else
                        begin
                            out_pin_next = cmd_pin_reg;
                            if (cmd_mode_reg == MODE_CLEAR)
                            begin
                                if (!slot_valid_reg[cmd_idx])
                                begin
                                    out_status_next = ST_NOT_CLEARED;
                                end
                                else
                                begin
                                    slot_valid_next[cmd_idx] = 1'b0;
                                end
                            end
                            else if (add_check != ST_OK)
                            begin
                                out_status_next = add_check;
                            end
                            else if (!cmd_present)
                            begin
                                // The old schedule stays removed.
                                slot_valid_next[cmd_idx] = 1'b0;
                                out_status_next          = ST_ABSENT;
                            end
                            else
                            begin
                                slot_valid_next[cmd_idx] = 1'b1;
                                mem_we                   = 1'b1;
                                out_id_next              = next_id_reg;
                                next_id_next             = next_id_reg + 1'b1;
                                out_written_next         = driven_reg[cmd_idx];
                                driven_next[cmd_idx]     = 1'b0;
                            end
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (advance)
                begin
                    if (ev_emit)
                    begin
                        out_load                    = 1'b1;
                        out_pin_next                = PIN_W'(ev_pin_reg);
                        out_level_next              = verdict.level;
                        out_written_next            = ev_write;
                        remembered_next[ev_pin_reg] = verdict.level;
                        if (ev_write)
                        begin
                            driven_next[ev_pin_reg] = verdict.level;
                        end
                    end
                    if (ev_valid_reg && ev_slot_ok && verdict.expire)
                    begin
                        slot_valid_next[ev_pin_reg] = 1'b0;
                    end
                    if (!scan_done)
                    begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_pin_next   = rd_addr_reg[IDX_W-1:0];
                        rd_addr_next  = rd_addr_reg + 1'b1;
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                        if (!ev_valid_reg)
                        begin
                            state_next = S_CLOSE;
                        end
                    end
                end
            end

            S_CLOSE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            present_reg    <= '0;
            slot_valid_reg <= '0;
            remembered_reg <= '0;
            driven_reg     <= '0;
            next_id_reg    <= ID_W'(1);
            rd_addr_reg    <= '0;
            ev_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            remembered_reg <= remembered_next;
            driven_reg     <= driven_next;
            next_id_reg    <= next_id_next;
            rd_addr_reg    <= rd_addr_next;
            ev_valid_reg   <= ev_valid_next;
            if (cfg_we)
            begin
                present_reg <= pwdata[MASK_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ev_pin_reg <= ev_pin_next;
        if (in_accept)
        begin
            cmd_mode_reg     <= mode;
            cmd_pin_reg      <= pin;
            cmd_kind_reg     <= schedule_kind;
            cmd_start_reg    <= start_time;
            cmd_end_reg      <= end_time;
            cmd_days_reg     <= days_mask;
            cmd_on_reg       <= on_minute;
            cmd_off_reg      <= off_minute;
            tick_reg.now     <= now_seconds;
            tick_reg.weekday <= weekday;
            tick_reg.minute  <= minute_of_day;
        end
        if (out_load)
        begin
            out_pin_reg     <= out_pin_next;
            out_level_reg   <= out_level_next;
            out_written_reg <= out_written_next;
            out_status_reg  <= out_status_next;
            out_id_reg      <= out_id_next;
            out_last_reg    <= out_last_next;
        end
    end

    // Schedule memory: one write port for add, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[cmd_idx] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr_reg[IDX_W-1:0]];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pin     = out_pin_reg;
    assign out_level   = out_level_reg;
    assign pin_written = out_written_reg;
    assign status      = out_status_reg;
    assign schedule_id = out_id_reg;
    assign last        = out_last_reg;

    // Checks on the sequencer.
    `PTSS_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_reg != S_IDLE)
    `PTSS_ASSERT_IMPLIES(a_eval_pin_in_range, ev_valid_reg, 32'(ev_pin_reg) < NUM_PINS)
    `PTSS_ASSERT_NEXT(a_id_only_on_add, !add_commit, $stable(next_id_reg))
    `PTSS_ASSERT_IMPLIES(a_load_needs_room, out_load, out_free)

endmodule

// ===== rtl/core/ptss_eval.sv =====
module ptss_eval (
    input  ptss_pkg::slot_t slot,
    input  ptss_pkg::tick_t tick,
    output ptss_pkg::eval_t verdict
);
    import ptss_pkg::*;

    logic in_window;
    logic past_end;
    logic day_hit;
    logic weekly_on;

    // One-time window compares.
    assign in_window = (tick.now >= slot.start_s) && (tick.now < slot.end_s);
    assign past_end  = (tick.now >= slot.end_s) && (slot.end_s != '0);

    // A weekday of seven matches no day.
    assign day_hit = (tick.weekday != 3'd7) && slot.days[tick.weekday];

    // Weekly window, wrapping past midnight when on is later than off.
    always_comb
    begin
        if (slot.on_m <= slot.off_m)
        begin
            weekly_on = (tick.minute >= slot.on_m) && (tick.minute < slot.off_m);
        end
        else
        begin
            weekly_on = (tick.minute >= slot.on_m) || (tick.minute < slot.off_m);
        end
    end

    // Combine into the wanted level.
    always_comb
    begin
        verdict = '0;
        if (!slot.weekly)
        begin
            if (in_window)
            begin
                verdict.want  = 1'b1;
                verdict.level = 1'b1;
            end
            else if (past_end)
            begin
                verdict.want   = 1'b1;
                verdict.expire = 1'b1;
            end
        end
        else if (day_hit)
        begin
            verdict.want  = 1'b1;
            verdict.level = weekly_on;
        end
    end

endmodule

// ===== tb/pin_time_schedule_switch_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the schedule switch, keeps its own
// picture of the per-pin schedules and levels, and compares every result item with the
// oldest one that it has worked out.
module pin_time_schedule_switch_checker
    import ptss_pkg::*;
#(
    parameter int NUM_PINS = NUM_PINS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [MODE_W-1:0]     mode,
    input  logic [PIN_W-1:0]      pin,
    input  logic                  schedule_kind,
    input  logic [TIME_W-1:0]     start_time,
    input  logic [TIME_W-1:0]     end_time,
    input  logic [DAYS_IN_W-1:0]  days_mask,
    input  logic [MIN_W-1:0]      on_minute,
    input  logic [MIN_W-1:0]      off_minute,
    input  logic [TIME_W-1:0]     now_seconds,
    input  logic [WDAY_W-1:0]     weekday,
    input  logic [MIN_W-1:0]      minute_of_day,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [PIN_W-1:0]      out_pin,
    input  logic                  out_level,
    input  logic                  pin_written,
    input  logic [STATUS_W-1:0]   status,
    input  logic [ID_W-1:0]       schedule_id,
    input  logic                  last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    input  logic [DATA_W-1:0]     prdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending,
    output int                    items_taken,
    output int                    results_taken
);

    localparam logic [ADDR_W-1:0] ADDR_PRESENT_MASK = '0;

    // One result item as the block should present it.
    typedef struct packed {
        logic [PIN_W-1:0]    pin;
        logic                level;
        logic                written;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic                last;
    } switch_report_t;

    switch_report_t    awaited_reports [$];

    // Own copy of the schedule store, the level memories and the register.
    slot_t             sched       [NUM_PINS];
    logic              sched_valid [NUM_PINS];
    logic              remembered  [NUM_PINS];
    logic              driven      [NUM_PINS];
    logic [ID_W-1:0]   next_id;
    logic [MASK_W-1:0] present;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic push_report(input logic [PIN_W-1:0] p, input logic lvl, input logic wr,
                               input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] id,
                               input logic fin);
        switch_report_t r;
        r.pin     = p;
        r.level   = lvl;
        r.written = wr;
        r.status  = st;
        r.id      = id;
        r.last    = fin;
        awaited_reports.insert(awaited_reports.size(), r);
    endtask

    // Works out the result items that the accepted item on the input channel causes.
    task automatic predict_switch();
        logic [7:0] day_bit;
        logic       want;
        logic       lvl;
        logic       expire;
        logic       wr;
        logic       fields_ok;
        slot_t      s;
        day_bit = 8'd1 << weekday;
        case (mode)
            MODE_TICK: begin
                // A tick without a valid time only closes.
                if (now_seconds != '0) begin
                    for (int q = 0; q < NUM_PINS; q++) begin
                        if (sched_valid[q]) begin
                            s      = sched[q];
                            want   = 1'b0;
                            lvl    = 1'b0;
                            expire = 1'b0;
                            if (!s.weekly) begin
                                if (now_seconds >= s.start_s && now_seconds < s.end_s) begin
                                    want = 1'b1;
                                    lvl  = 1'b1;
                                end else if (now_seconds >= s.end_s && s.end_s != '0) begin
                                    want   = 1'b1;
                                    expire = 1'b1;
                                end
                            end else if (({1'b0, s.days} & day_bit) != 8'd0) begin
                                want = 1'b1;
                                // An on minute past the off minute wraps over midnight.
                                if (s.on_m <= s.off_m)
                                    lvl = (minute_of_day >= s.on_m) && (minute_of_day < s.off_m);
                                else
                                    lvl = (minute_of_day >= s.on_m) || (minute_of_day < s.off_m);
                            end
                            if (want && remembered[q] != lvl) begin
                                remembered[q] = lvl;
                                wr = 1'b0;
                                if (present[q] && driven[q] != lvl) begin
                                    driven[q] = lvl;
                                    wr = 1'b1;
                                end
                                push_report(PIN_W'(q), lvl, wr, ST_OK, '0, 1'b0);
                            end
                            if (expire)
                                sched_valid[q] = 1'b0;
                        end
                    end
                end
                push_report('0, 1'b0, 1'b0, ST_OK, '0, 1'b1);
            end
            MODE_ADD: begin
                if (pin > PIN_MAX || int'(pin) >= NUM_PINS) begin
                    push_report('0, 1'b0, 1'b0, ST_BAD_PIN, '0, 1'b1);
                end else begin
                    fields_ok = 1'b0;
                    if (!schedule_kind) begin
                        if (start_time > TIME_MAX || end_time > TIME_MAX)
                            push_report(pin, 1'b0, 1'b0, ST_BAD_TIME, '0, 1'b1);
                        else if (end_time <= start_time)
                            push_report(pin, 1'b0, 1'b0, ST_BAD_RANGE, '0, 1'b1);
                        else
                            fields_ok = 1'b1;
                    end else begin
                        if (days_mask > DAYS_MAX || on_minute > MINUTE_MAX
                            || off_minute > MINUTE_MAX)
                            push_report(pin, 1'b0, 1'b0, ST_BAD_TIME, '0, 1'b1);
                        else if (on_minute == off_minute)
                            push_report(pin, 1'b0, 1'b0, ST_BAD_RANGE, '0, 1'b1);
                        else
                            fields_ok = 1'b1;
                    end
                    if (fields_ok) begin
                        // The old schedule goes even when the pin turns out to be absent.
                        sched_valid[pin] = 1'b0;
                        if (!present[pin]) begin
                            push_report(pin, 1'b0, 1'b0, ST_ABSENT, '0, 1'b1);
                        end else begin
                            s.weekly  = schedule_kind;
                            s.start_s = schedule_kind ? '0 : start_time;
                            s.end_s   = schedule_kind ? '0 : end_time;
                            s.days    = schedule_kind ? days_mask[DAYS_W-1:0] : '0;
                            s.on_m    = schedule_kind ? on_minute : '0;
                            s.off_m   = schedule_kind ? off_minute : '0;
                            sched[pin]       = s;
                            sched_valid[pin] = 1'b1;
                            wr               = driven[pin];
                            driven[pin]      = 1'b0;
                            push_report(pin, 1'b0, wr, ST_OK, next_id, 1'b1);
                            next_id++;
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                if (pin > PIN_MAX || int'(pin) >= NUM_PINS) begin
                    push_report('0, 1'b0, 1'b0, ST_BAD_PIN, '0, 1'b1);
                end else if (!sched_valid[pin]) begin
                    push_report(pin, 1'b0, 1'b0, ST_NOT_CLEARED, '0, 1'b1);
                end else begin
                    sched_valid[pin] = 1'b0;
                    push_report(pin, 1'b0, 1'b0, ST_OK, '0, 1'b1);
                end
            end
            default: begin
                push_report('0, 1'b0, 1'b0, ST_OK, '0, 1'b1);
            end
        endcase
    endtask

    // All channels are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk) begin : watch
        switch_report_t r;
        if (!rst_n) begin
            for (int q = 0; q < NUM_PINS; q++) begin
                sched_valid[q] = 1'b0;
                remembered[q]  = 1'b0;
                driven[q]      = 1'b0;
                sched[q]       = '0;
            end
            next_id       = 1;
            present       = '0;
            mismatches    = 0;
            items_taken   = 0;
            results_taken = 0;
            awaited_reports.delete();
        end else begin
            // Register access phase.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == ADDR_PRESENT_MASK)
                        present = pwdata[MASK_W-1:0];
                end else if (paddr == ADDR_PRESENT_MASK
                             && prdata !== {{(DATA_W-MASK_W){1'b0}}, present}) begin
                    report_mismatch($sformatf("prdata %0h, expected %0h", prdata, present));
                end
            end

            // Result items against the oldest expectation.
            if (out_valid && !out_stall) begin
                results_taken++;
                if (awaited_reports.size() == 0) begin
                    report_mismatch($sformatf("result item for pin %0d with nothing outstanding",
                                              out_pin));
                end else begin
                    r = awaited_reports.pop_front();
                    if (out_pin !== r.pin)
                        report_mismatch($sformatf("out_pin %0d, expected %0d", out_pin, r.pin));
                    if (out_level !== r.level)
                        report_mismatch($sformatf("out_level %0b, expected %0b on pin %0d",
                                                  out_level, r.level, r.pin));
                    if (pin_written !== r.written)
                        report_mismatch($sformatf("pin_written %0b, expected %0b on pin %0d",
                                                  pin_written, r.written, r.pin));
                    if (status !== r.status)
                        report_mismatch($sformatf("status %0d, expected %0d on pin %0d",
                                                  status, r.status, r.pin));
                    if (schedule_id !== r.id)
                        report_mismatch($sformatf("schedule_id %0d, expected %0d on pin %0d",
                                                  schedule_id, r.id, r.pin));
                    if (last !== r.last)
                        report_mismatch($sformatf("last %0b, expected %0b on pin %0d",
                                                  last, r.last, r.pin));
                end
            end

            // Accepted input item.
            if (in_valid && !in_stall) begin
                items_taken++;
                predict_switch();
            end
        end
        pending = awaited_reports.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Drives commands and ticks into the schedule switch with idle bursts on both channels,
// walks the present mask through several settings and gives the verdict.
module tb;
    import ptss_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED       = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_PRESENT_MASK = '0;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED     = 4'd8;
    localparam logic [MASK_W-1:0] MASK_ALL          = {MASK_W{1'b1}};
    localparam logic [MASK_W-1:0] MASK_ALTERNATE    = 40'h55_5555_5555;
    localparam int                SETTLE_CYCLES     = 8;
    localparam int                TAIL_CYCLES       = 60;
    localparam int                LONG_HOLD_CYCLES  = 300;
    localparam longint            LIMIT_NS          = 12_000_000;

    // One input item.
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [PIN_W-1:0]     pin;
        logic                 kind;
        logic [TIME_W-1:0]    start_s;
        logic [TIME_W-1:0]    end_s;
        logic [DAYS_IN_W-1:0] days;
        logic [MIN_W-1:0]     on_m;
        logic [MIN_W-1:0]     off_m;
        logic [TIME_W-1:0]    now;
        logic [WDAY_W-1:0]    wday;
        logic [MIN_W-1:0]     mins;
    } command_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode          = '0;
    logic [PIN_W-1:0]      pin           = '0;
    logic                  schedule_kind = 1'b0;
    logic [TIME_W-1:0]     start_time    = '0;
    logic [TIME_W-1:0]     end_time      = '0;
    logic [DAYS_IN_W-1:0]  days_mask     = '0;
    logic [MIN_W-1:0]      on_minute     = '0;
    logic [MIN_W-1:0]      off_minute    = '0;
    logic [TIME_W-1:0]     now_seconds   = '0;
    logic [WDAY_W-1:0]     weekday       = '0;
    logic [MIN_W-1:0]      minute_of_day = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [PIN_W-1:0]      out_pin;
    logic                  out_level;
    logic                  pin_written;
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       schedule_id;
    logic                  last;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [DATA_W-1:0]     pwdata        = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending;
    int                    items_taken;
    int                    results_taken;

    bit                    idling            = 1'b1;
    int                    long_holds_asked  = 0;
    int                    long_holds_done   = 0;
    logic [TIME_W-1:0]     clock_s;

    pin_time_schedule_switch i_dut (.*);

    pin_time_schedule_switch_checker i_checker (.*);

    always #5 clk = ~clk;

    // Every field random over its whole width; the builders below overwrite what they use.
    function automatic command_t noise_command();
        command_t c;
        c.mode    = MODE_W'($urandom());
        c.pin     = PIN_W'($urandom());
        c.kind    = 1'($urandom());
        c.start_s = TIME_W'({$urandom(), $urandom()});
        c.end_s   = TIME_W'({$urandom(), $urandom()});
        c.days    = DAYS_IN_W'($urandom());
        c.on_m    = MIN_W'($urandom());
        c.off_m   = MIN_W'($urandom());
        c.now     = TIME_W'({$urandom(), $urandom()});
        c.wday    = WDAY_W'($urandom());
        c.mins    = MIN_W'($urandom());
        return c;
    endfunction

    function automatic command_t add_once(input logic [PIN_W-1:0] p,
                                          input logic [TIME_W-1:0] st,
                                          input logic [TIME_W-1:0] en);
        command_t c;
        c         = noise_command();
        c.mode    = MODE_ADD;
        c.pin     = p;
        c.kind    = 1'b0;
        c.start_s = st;
        c.end_s   = en;
        return c;
    endfunction

    function automatic command_t add_weekly(input logic [PIN_W-1:0] p,
                                            input logic [DAYS_IN_W-1:0] d,
                                            input logic [MIN_W-1:0] on_m,
                                            input logic [MIN_W-1:0] off_m);
        command_t c;
        c       = noise_command();
        c.mode  = MODE_ADD;
        c.pin   = p;
        c.kind  = 1'b1;
        c.days  = d;
        c.on_m  = on_m;
        c.off_m = off_m;
        return c;
    endfunction

    function automatic command_t clear_command(input logic [PIN_W-1:0] p);
        command_t c;
        c      = noise_command();
        c.mode = MODE_CLEAR;
        c.pin  = p;
        return c;
    endfunction

    function automatic command_t tick_command(input logic [TIME_W-1:0] now,
                                              input logic [WDAY_W-1:0] wd,
                                              input logic [MIN_W-1:0] mins);
        command_t c;
        c      = noise_command();
        c.mode = MODE_TICK;
        c.now  = now;
        c.wday = wd;
        c.mins = mins;
        return c;
    endfunction

    // Mostly a handful of low pins so that schedules meet each other, sometimes bad ones.
    function automatic logic [PIN_W-1:0] pick_pin();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return PIN_W'($urandom_range(0, 7));
        if (r < 9)
            return PIN_W'($urandom_range(0, 39));
        return PIN_W'($urandom_range(40, 63));
    endfunction

    // Well-formed schedules around a running clock and ticks that walk through them,
    // with some broken adds and plain noise mixed in.
    function automatic command_t random_command();
        command_t c;
        int       r;
        int       k;
        r = $urandom_range(0, 99);
        if (r < 16) begin
            c = add_once(pick_pin(), '0, '0);
            c.start_s = clock_s - TIME_W'($urandom_range(0, 20)) + TIME_W'($urandom_range(0, 40));
            c.end_s   = c.start_s + TIME_W'($urandom_range(1, 60));
            k = $urandom_range(0, 19);
            if (k < 2)
                c.end_s = c.start_s - TIME_W'($urandom_range(0, 3));
            else if (k == 2)
                c.start_s = TIME_MAX + TIME_W'($urandom_range(1, 1000));
        end else if (r < 32) begin
            c = add_weekly(pick_pin(), DAYS_IN_W'($urandom_range(0, 127)),
                           MIN_W'($urandom_range(0, 1440)), MIN_W'($urandom_range(0, 1440)));
            k = $urandom_range(0, 19);
            if (k < 2)
                c.off_m = c.on_m;
            else if (k == 2)
                c.on_m = MIN_W'($urandom_range(1441, 2047));
            else if (k == 3)
                c.days = DAYS_IN_W'($urandom_range(128, 255));
        end else if (r < 40) begin
            c = clear_command(pick_pin());
        end else if (r < 93) begin
            clock_s = clock_s + TIME_W'($urandom_range(0, 15));
            c = tick_command(clock_s, WDAY_W'($urandom_range(0, 6)),
                             MIN_W'($urandom_range(0, 1439)));
            if ($urandom_range(0, 29) == 0)
                c.now = '0;
            if ($urandom_range(0, 19) == 0)
                c.wday = WDAY_W'(7);
        end else begin
            c = noise_command();
        end
        return c;
    endfunction

    // Offers one item, perhaps after an idle burst, and returns at the edge that takes it.
    task automatic drive_item(input command_t c);
        if (idling && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= c.mode;
        pin           <= c.pin;
        schedule_kind <= c.kind;
        start_time    <= c.start_s;
        end_time      <= c.end_s;
        days_mask     <= c.days;
        on_minute     <= c.on_m;
        off_minute    <= c.off_m;
        now_seconds   <= c.now;
        weekday       <= c.wday;
        minute_of_day <= c.mins;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops offering and waits until every awaited result item has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Sets the present mask on an idle block and runs random items against it.
    task automatic run_phase(input logic [MASK_W-1:0] mask_value, input int count,
                             input bit with_idle, input int hold_at, input int pause_at);
        apb_access(1'b1, ADDR_PRESENT_MASK, {{(DATA_W-MASK_W){1'b0}}, mask_value});
        apb_access(1'b0, ADDR_PRESENT_MASK, '0);
        clock_s = TIME_W'($urandom_range(1000, 32'd4102344800));
        idling  = with_idle;
        for (int i = 0; i < count; i++) begin
            if (with_idle && i % 25 == 0)
                idling = ($urandom_range(0, 3) != 0);
            if (i == hold_at)
                long_holds_asked++;
            if (i == pause_at)
                wait_drained();
            drive_item(random_command());
        end
        wait_drained();
    endtask

    // Receiver: random stall bursts, and a long hold when the stimulus asks for one.
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (long_holds_done != long_holds_asked) begin
                long_holds_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (idling && $urandom_range(0, 11) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no pin present an add is refused and a clear finds nothing.
        drive_item(add_once(PIN_W'(3), TIME_W'(100), TIME_W'(200)));
        drive_item(clear_command(PIN_W'(3)));
        drive_item(noise_command() | '0);
        wait_drained();

        apb_access(1'b1, ADDR_PRESENT_MASK, {{(DATA_W-MASK_W){1'b0}}, MASK_ALL});
        apb_access(1'b1, ADDR_UNMAPPED, {$urandom(), $urandom()});
        apb_access(1'b0, ADDR_PRESENT_MASK, '0);

        // Field checks: bad pins, times past the limit, empty ranges.
        drive_item(add_once(PIN_W'(63), TIME_W'(100), TIME_W'(200)));
        drive_item(add_weekly(PIN_W'(40), DAYS_IN_W'(127), MIN_W'(60), MIN_W'(120)));
        drive_item(clear_command(PIN_W'(63)));
        drive_item(add_once(PIN_W'(5), TIME_MAX + TIME_W'(1), TIME_MAX));
        drive_item(add_once(PIN_W'(5), TIME_W'(10), TIME_MAX + TIME_W'(1)));
        drive_item(add_once(PIN_W'(5), TIME_W'(500), TIME_W'(500)));
        drive_item(add_weekly(PIN_W'(6), DAYS_IN_W'(128), MIN_W'(0), MIN_W'(10)));
        drive_item(add_weekly(PIN_W'(6), DAYS_IN_W'(127), MIN_W'(1441), MIN_W'(0)));
        drive_item(add_weekly(PIN_W'(6), DAYS_IN_W'(127), MIN_W'(0), MIN_W'(2047)));
        drive_item(add_weekly(PIN_W'(6), DAYS_IN_W'(5), MIN_W'(700), MIN_W'(700)));

        // Valid schedules: widest one-time window, overnight, whole day, on at the day's end.
        drive_item(add_once(PIN_W'(0), TIME_W'(1000), TIME_W'(2000)));
        drive_item(add_once(PIN_W'(39), '0, TIME_MAX));
        drive_item(add_weekly(PIN_W'(1), DAYS_IN_W'(127), MIN_W'(1320), MIN_W'(120)));
        drive_item(add_weekly(PIN_W'(2), DAYS_IN_W'(1), MIN_W'(0), MIN_W'(1440)));
        drive_item(add_weekly(PIN_W'(4), DAYS_IN_W'(127), MIN_W'(1440), MIN_W'(30)));

        // A tick without time, then one that lights most of the scheduled pins.
        drive_item(tick_command('0, WDAY_W'(0), MIN_W'(60)));
        drive_item(tick_command(TIME_W'(1500), WDAY_W'(0), MIN_W'(60)));
        // Re-adding a lit pin drives it low but leaves its remembered level high.
        drive_item(add_weekly(PIN_W'(1), DAYS_IN_W'(127), MIN_W'(1320), MIN_W'(120)));
        // Expiry of a one-time window, and a weekday that matches no day.
        drive_item(tick_command(TIME_W'(2000), WDAY_W'(7), MIN_W'(1439)));
        drive_item(tick_command({TIME_W{1'b1}}, WDAY_W'(6), MIN_W'(600)));
        drive_item(clear_command(PIN_W'(2)));
        drive_item(clear_command(PIN_W'(2)));
        wait_drained();

        // Random phases over several present masks; the last one runs without idling.
        run_phase(MASK_ALL, 100, 1'b1, -1, -1);
        run_phase(MASK_W'({$urandom(), $urandom()}), 100, 1'b1, 30, 70);
        run_phase('0, 40, 1'b1, -1, -1);
        run_phase(MASK_ALTERNATE, 100, 1'b0, -1, -1);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d items: directed field checks, then all, random, empty and alternate masks.",
                 items_taken);
        $display("Checked %0d result items under idle bursts and one long output hold.",
                 results_taken);
        if (mismatches == 0 && pending == 0)
            $display("pin_time_schedule_switch regression: pass");
        else
            $display("pin_time_schedule_switch regression: fail");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("pin_time_schedule_switch regression: fail");
        $finish;
    end

endmodule
